/* rtl/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define LSR_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define LSR_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/lsr_pkg.sv */
`timescale 1ns / 1ps

package lsr_pkg;

  localparam int SET_WIDTH = 32;
  localparam int FIELD_W   = 32;
  localparam int CNT_W     = 6;
  localparam int IDX_W     = $clog2(FIELD_W);
  // Largest usable universe: bounded by the set width and by the field width.
  localparam int MAX_N     = (SET_WIDTH < FIELD_W) ? SET_WIDTH : FIELD_W;

  localparam logic [CNT_W-1:0] UNIV_RESET = CNT_W'(32);
  localparam logic [CNT_W-1:0] N_LIMIT    = CNT_W'(MAX_N);

  // Unrank compare-subtract steps handled per pipeline stage.
  localparam int STEPS_PER_STG = 4;
  localparam int UNRANK_STG    = (MAX_N + STEPS_PER_STG - 1) / STEPS_PER_STG;

  localparam logic [1:0] KIND_RANK   = 2'd0;
  localparam logic [1:0] KIND_UNRANK = 2'd1;
  localparam logic [1:0] KIND_NEXT   = 2'd2;

  typedef logic [FIELD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef struct packed {
    logic [1:0] kind;
    word_t      subset_mask;
    word_t      rank_in;
  } in_t;

  typedef struct packed {
    word_t subset_mask_out;
    cnt_t  member_count;
    word_t rank_out;
    logic  has_next;
    logic  bad_input;
  } out_t;

  // Item in flight through the front and unrank stages.
  typedef struct packed {
    word_t m;    // result mask so far
    word_t r;    // remaining rank (unrank only, zero otherwise)
    word_t w;    // weight of the current element
    word_t cur;  // one-hot position of the current element
    cnt_t  n;
    logic  hn;
    logic  bad;
  } pipe_t;

  // Item between the two halves of the rank computation.
  typedef struct packed {
    word_t m;
    word_t wsum;
    cnt_t  k;
    logic  hn;
    logic  bad;
  } rk_t;

  function automatic idx_t top_index(word_t v);
    idx_t t;
    t = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (v[i]) t = idx_t'(i);
    end
    return t;
  endfunction

  function automatic cnt_t pop_count(word_t v);
    cnt_t c;
    c = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      c = c + cnt_t'(v[i]);
    end
    return c;
  endfunction

  function automatic word_t bit_rev(word_t v);
    word_t o;
    for (int i = 0; i < FIELD_W; i++) begin
      o[i] = v[FIELD_W-1-i];
    end
    return o;
  endfunction

endpackage

/* rtl/lex_subset_rank_unrank_core.sv */
`timescale 1ns / 1ps

// Lexicographic subset rank, unrank and successor over subsets of {0..n-1}, carried as
// bit masks (bit i set when element i is a member). Each input beat carries a kind: rank
// a mask, unrank rank_in to a mask, or step a mask to its successor; kind 3, a rank or
// successor mask with bits at or above n, or an unrank rank_in of 2^n or more returns
// bad_input with all other fields zero. Every result beat carries the result mask, its
// member count and its rank. n is the universe size (reset 32), saturated to 32; write it
// through cfg_we/cfg_data only while no beat is in flight. One beat is taken every cycle
// unless output stalls back up the pipeline. It has one decode and successor stage,
// eight unrank stages of four compare-subtract steps each (the unrank chain of 32 steps
// sets the depth), then two rank stages (popcount and weight sum, then the final add).
// Each stage has its own valid bit and loads when it is empty or its successor moves, so
// bubbles squeeze out and a stalled output beat holds while earlier stages keep filling.
module lex_subset_rank_unrank_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  lsr_pkg::cnt_t  cfg_data,
  input  logic           in_valid,
  output logic           in_stall,
  input  lsr_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lsr_pkg::out_t  out_data
);

  localparam int NSTG = lsr_pkg::UNRANK_STG;

  lsr_pkg::cnt_t  universe;
  lsr_pkg::cnt_t  n_eff;
  logic           front_ready;
  logic           stg_valid [NSTG+1];
  logic           stg_ready [NSTG+1];
  lsr_pkg::pipe_t stg_data  [NSTG+1];

  // Hold the universe size; write only while idle (the block does not enforce this).
  always_ff @(posedge clk) begin
    if (rst) begin
      universe <= lsr_pkg::UNIV_RESET;
    end else if (cfg_we) begin
      universe <= cfg_data;
    end
  end

  // Saturate to the widest usable universe.
  assign n_eff    = (universe > lsr_pkg::N_LIMIT) ? lsr_pkg::N_LIMIT : universe;
  assign in_stall = !front_ready;

  // Decode, validity checks and successor mask.
  lsr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .n        (n_eff),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_ready (front_ready),
    .dn_valid (stg_valid[0]),
    .dn_data  (stg_data[0]),
    .dn_ready (stg_ready[0])
  );

  // Unrank chain, a few elements per stage; other kinds pass through untouched.
  for (genvar g = 0; g < NSTG; g++) begin : g_unrank
    lsr_unrank_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stg_valid[g]),
      .up_data  (stg_data[g]),
      .up_ready (stg_ready[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_data  (stg_data[g+1]),
      .dn_ready (stg_ready[g+1])
    );
  end

  // Rank of the final mask, member count, and the output register.
  lsr_rank u_rank (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stg_valid[NSTG]),
    .up_data  (stg_data[NSTG]),
    .up_ready (stg_ready[NSTG]),
    .dn_valid (out_valid),
    .dn_data  (out_data),
    .dn_ready (!out_stall)
  );

endmodule

/* rtl/lsr_front.sv */
`timescale 1ns / 1ps

module lsr_front (
  input  logic             clk,
  input  logic             rst,
  input  lsr_pkg::cnt_t    n,
  input  logic             up_valid,
  input  lsr_pkg::in_t     up_data,
  output logic             up_ready,
  output logic             dn_valid,
  output lsr_pkg::pipe_t   dn_data,
  input  logic             dn_ready
);

  logic [lsr_pkg::FIELD_W:0] full_wide;
  lsr_pkg::word_t full;
  lsr_pkg::word_t mask;
  lsr_pkg::word_t rest;
  lsr_pkg::word_t succ;
  lsr_pkg::idx_t  t;
  lsr_pkg::idx_t  s;
  lsr_pkg::cnt_t  t_ext;
  lsr_pkg::cnt_t  s_ext;
  logic           mask_bad;
  logic           rank_bad;
  logic           succ_hn;
  lsr_pkg::pipe_t stage_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    mask      = up_data.subset_mask;
    full_wide = ({{lsr_pkg::FIELD_W{1'b0}}, 1'b1} << n) - 1'b1;
    full      = full_wide[lsr_pkg::FIELD_W-1:0];
    mask_bad  = |(mask & ~full);
    rank_bad  = up_data.rank_in > full;

    // Successor: {0} after {}, extend past the top, else carry the next one up.
    t     = lsr_pkg::top_index(mask);
    t_ext = lsr_pkg::cnt_t'(t);
    rest  = mask & ~(lsr_pkg::word_t'(1) << t);
    s     = lsr_pkg::top_index(rest);
    s_ext = lsr_pkg::cnt_t'(s);
    if (mask == '0) begin
      succ    = (n != '0) ? lsr_pkg::word_t'(1) : '0;
      succ_hn = (n != '0);
    end else if (t_ext == n - 1'b1) begin
      if (rest == '0) begin
        succ    = mask;
        succ_hn = 1'b0;
      end else begin
        succ    = (rest & ~(lsr_pkg::word_t'(1) << s))
                | (lsr_pkg::word_t'(1) << (s_ext + 1'b1));
        succ_hn = 1'b1;
      end
    end else begin
      succ    = mask | (lsr_pkg::word_t'(1) << (t_ext + 1'b1));
      succ_hn = 1'b1;
    end

    stage_next     = '0;
    stage_next.n   = n;
    stage_next.cur = lsr_pkg::word_t'(1);
    case (up_data.kind)
      lsr_pkg::KIND_RANK: begin
        stage_next.bad = mask_bad;
        stage_next.m   = mask;
      end
      lsr_pkg::KIND_UNRANK: begin
        stage_next.bad = rank_bad;
        stage_next.r   = up_data.rank_in;
        stage_next.w   = (n != '0) ? (lsr_pkg::word_t'(1) << (n - 1'b1)) : '0;
      end
      lsr_pkg::KIND_NEXT: begin
        stage_next.bad = mask_bad;
        stage_next.m   = succ;
        stage_next.hn  = succ_hn;
      end
      default: begin
        stage_next.bad = 1'b1;
      end
    endcase
    // Zero the payload of a bad beat so later stages produce all-zero fields.
    if (stage_next.bad) begin
      stage_next.m  = '0;
      stage_next.r  = '0;
      stage_next.w  = '0;
      stage_next.hn = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= stage_next;
    end
  end

endmodule

/* rtl/lsr_unrank_stage.sv */
`timescale 1ns / 1ps

module lsr_unrank_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  input  lsr_pkg::pipe_t up_data,
  output logic           up_ready,
  output logic           dn_valid,
  output lsr_pkg::pipe_t dn_data,
  input  logic           dn_ready
);

  lsr_pkg::pipe_t stage_next;

  assign up_ready = !dn_valid || dn_ready;

  // Compare-subtract steps; a zero rank or zero weight leaves the mask and rank alone.
  always_comb begin
    stage_next = up_data;
    for (int i = 0; i < lsr_pkg::STEPS_PER_STG; i++) begin
      if (stage_next.w != '0 && stage_next.r != '0) begin
        if (stage_next.r <= stage_next.w) begin
          stage_next.m = stage_next.m | stage_next.cur;
          stage_next.r = stage_next.r - 1'b1;
        end else begin
          stage_next.r = stage_next.r - stage_next.w;
        end
      end
      stage_next.w   = stage_next.w >> 1;
      stage_next.cur = stage_next.cur << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= stage_next;
    end
  end

endmodule

/* rtl/lsr_rank.sv */
`timescale 1ns / 1ps

module lsr_rank (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  input  lsr_pkg::pipe_t up_data,
  output logic           up_ready,
  output logic           dn_valid,
  output lsr_pkg::out_t  dn_data,
  input  logic           dn_ready
);

  logic           mid_valid;
  logic           mid_ready;
  lsr_pkg::rk_t   mid;
  lsr_pkg::rk_t   mid_next;
  lsr_pkg::out_t  out_next;
  lsr_pkg::word_t below;
  lsr_pkg::idx_t  t;

  assign mid_ready = !dn_valid || dn_ready;
  assign up_ready  = !mid_valid || mid_ready;

  // Rank = members + weights of the non-members below the top element.
  always_comb begin
    t             = lsr_pkg::top_index(up_data.m);
    below         = (lsr_pkg::word_t'(1) << t) - 1'b1;
    mid_next.m    = up_data.m;
    mid_next.k    = lsr_pkg::pop_count(up_data.m);
    mid_next.wsum = lsr_pkg::bit_rev(~up_data.m & below)
                  >> (lsr_pkg::cnt_t'(lsr_pkg::FIELD_W) - up_data.n);
    mid_next.hn   = up_data.hn;
    mid_next.bad  = up_data.bad;
  end

  always_comb begin
    out_next.subset_mask_out = mid.m;
    out_next.member_count    = mid.k;
    out_next.rank_out        = mid.wsum + lsr_pkg::word_t'(mid.k);
    out_next.has_next        = mid.hn;
    out_next.bad_input       = mid.bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      dn_valid  <= 1'b0;
    end else begin
      if (up_ready) begin
        mid_valid <= up_valid;
      end
      if (mid_ready) begin
        dn_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      mid <= mid_next;
    end
    if (mid_ready && mid_valid) begin
      dn_data <= out_next;
    end
  end

endmodule

/* rtl/lsr_checker.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lsr_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input lsr_pkg::out_t out_data
);

  logic out_held;
  logic bad_beat;
  logic bad_fields_zero;

  assign out_held        = out_valid && out_stall;
  assign bad_beat        = out_valid && out_data.bad_input;
  assign bad_fields_zero = out_data.subset_mask_out == '0 && out_data.rank_out == '0
                        && out_data.member_count == '0 && !out_data.has_next;

  // Pipeline must come out of reset empty.
  `LSR_ASSERT_ALL(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")

  // With the output draining, every stage can load, so the input never stalls.
  `LSR_ASSERT_ALL(a_no_stall_when_drained, clk, !out_stall |-> !in_stall, "stall while draining")

  // A bad beat carries nothing else.
  `LSR_ASSERT_CLK(a_bad_zero, clk, rst, bad_beat |-> bad_fields_zero, "bad beat not zeroed")

  // Stalled result beat holds.
  `LSR_ASSERT_CLK(a_out_hold, clk, rst, out_held |=> out_valid, "stalled beat dropped")
  `LSR_ASSERT_CLK(a_data_hold, clk, rst, out_held |=> $stable(out_data), "stalled beat changed")

endmodule

bind lex_subset_rank_unrank_core lsr_checker u_lsr_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 1ps

// Bench for the lexicographic subset rank / unrank / successor core.
// Stimulus runs as a series of named tests sharing one beat sender; a single
// monitor process compares every output beat against a queue of predicted
// results, computed by a behavioural model of the ordering held in this file.
module tb;
  import lsr_pkg::*;

  // Kind 3 is unused by the core and must come back flagged as bad input.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  // Pipeline depth is eleven stages; allow a margin when draining.
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_LIMIT  = 40;
  localparam int IDLE_PCT     = 12;

  logic  clk;
  logic  rst       = 1'b1;
  logic  cfg_we    = 1'b0;
  cnt_t  cfg_data  = '0;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  in_t   in_data   = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  // Bench copy of the universe register; tracks the core's reset value.
  cnt_t  universe_reg = UNIV_RESET;

  out_t  pending_results[$];
  int    mismatches      = 0;
  int    beats_sent      = 0;
  int    results_checked = 0;
  int    universe_writes = 0;
  int    cycle_count     = 0;
  int    send_idle_pct   = IDLE_PCT;
  int    sink_stall_pct  = IDLE_PCT;

  lex_subset_rank_unrank_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Ordering model
  // ---------------------------------------------------------------------------

  // Universe size as the core uses it: saturated to the 32-bit field width.
  function automatic int unsigned effective_n(cnt_t univ);
    return (univ > 6'd32) ? 32 : int'(univ);
  endfunction

  function automatic int highest_member(logic [63:0] m);
    int hi;
    hi = 0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) hi = i;
    end
    return hi;
  endfunction

  // Rank = member count plus the weight 2^(n-1-i) of every absentee i lying
  // below the top member.
  function automatic logic [63:0] lex_rank(logic [63:0] m, int unsigned n);
    logic [63:0] acc;
    int unsigned members;
    int unsigned seen;
    acc     = '0;
    members = $countones(m);
    seen    = 0;
    for (int unsigned i = 0; i < n && seen < members; i++) begin
      if (m[i]) seen++;
      else acc += 64'd1 << (n - 1 - i);
    end
    return acc + 64'(members);
  endfunction

  // Walk the elements in order: take an element when the rank left fits
  // within its subtree, otherwise skip the whole subtree.
  function automatic logic [63:0] lex_unrank(logic [63:0] r, int unsigned n);
    logic [63:0] m;
    logic [63:0] w;
    m = '0;
    for (int unsigned i = 0; i < n; i++) begin
      w = 64'd1 << (n - 1 - i);
      if (r <= w) begin
        if (r == 0) break;
        m[i] = 1'b1;
        r    = r - 1;
      end else begin
        r = r - w;
      end
    end
    return m;
  endfunction

  function automatic out_t subset_result(in_t item, cnt_t univ);
    out_t        o;
    int unsigned n;
    logic [63:0] full;
    logic [63:0] mask;
    logic [63:0] res;
    logic [63:0] rest;
    logic [63:0] rnk;
    logic        hn;
    logic        bad;
    int          top;
    int          low;
    n    = effective_n(univ);
    full = (64'd1 << n) - 64'd1;
    mask = 64'(item.subset_mask);
    res  = '0;
    rnk  = '0;
    hn   = 1'b0;
    bad  = 1'b0;
    case (item.kind)
      KIND_RANK: begin
        if ((mask & ~full) != 0) bad = 1'b1;
        else begin
          res = mask;
          rnk = lex_rank(res, n);
        end
      end
      KIND_UNRANK: begin
        if (64'(item.rank_in) > full) bad = 1'b1;
        else begin
          res = lex_unrank(64'(item.rank_in), n);
          rnk = 64'(item.rank_in);
        end
      end
      KIND_NEXT: begin
        if ((mask & ~full) != 0) begin
          bad = 1'b1;
        end else if (mask == 0) begin
          // Empty set steps to {0}, unless the universe itself is empty.
          if (n > 0) begin
            res = 64'd1;
            hn  = 1'b1;
          end
        end else begin
          top = highest_member(mask);
          if (top == int'(n) - 1) begin
            if ($countones(mask) == 1) begin
              // {n-1} is the last subset: hold the mask, flag no successor.
              res = mask;
            end else begin
              // Drop the top member and advance the next one up by a place.
              rest = mask & ~(64'd1 << top);
              low  = highest_member(rest);
              res  = (rest & ~(64'd1 << low)) | (64'd1 << (low + 1));
              hn   = 1'b1;
            end
          end else begin
            res = mask | (64'd1 << (top + 1));
            hn  = 1'b1;
          end
        end
        if (!bad) rnk = lex_rank(res, n);
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      res = '0;
      rnk = '0;
      hn  = 1'b0;
    end
    o.subset_mask_out = res[31:0];
    o.member_count    = bad ? cnt_t'(0) : cnt_t'($countones(res));
    o.rank_out        = rnk[31:0];
    o.has_next        = hn;
    o.bad_input       = bad;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_t make_beat(logic [1:0] kind, word_t mask, word_t rank);
    in_t it;
    it.kind        = kind;
    it.subset_mask = mask;
    it.rank_in     = rank;
    return it;
  endfunction

  // Mostly well-formed operands for the current universe, with masks shaped
  // to reach each successor branch; a small share of out-of-range noise.
  function automatic in_t random_beat(cnt_t univ);
    in_t         it;
    int unsigned n;
    int unsigned pick;
    logic [63:0] full;
    logic [63:0] mask;
    logic [63:0] rank;
    n    = effective_n(univ);
    full = (64'd1 << n) - 64'd1;
    pick = $urandom_range(0, 99);
    if (pick < 31)      it.kind = KIND_RANK;
    else if (pick < 62) it.kind = KIND_UNRANK;
    else if (pick < 96) it.kind = KIND_NEXT;
    else                it.kind = KIND_SPARE;
    mask = 64'($urandom) & full;
    case ($urandom_range(0, 7))
      1: begin
        mask = '0;
        if (n > 0) begin
          repeat ($urandom_range(1, 3)) mask[$urandom_range(0, n - 1)] = 1'b1;
        end
      end
      2: if (n > 0) mask[n - 1] = 1'b1;
      3: mask = (n > 0) ? (64'd1 << (n - 1)) : 64'd0;
      4: mask = '0;
      5: mask = full;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: rank = '0;
      1: rank = full;
      2: rank = 64'($urandom_range(0, 40)) & full;
      default: rank = 64'($urandom) & full;
    endcase
    if (n < 32 && $urandom_range(0, 99) < 8) begin
      mask = mask | (64'd1 << n) | (64'($urandom) & ~full);
      rank = rank | (64'd1 << n) | (64'($urandom) & ~full);
    end
    // Unused operand carries random content so every bit toggles.
    if (it.kind != KIND_UNRANK) rank = 64'($urandom);
    it.subset_mask = mask[31:0];
    it.rank_in     = rank[31:0];
    return it;
  endfunction

  // Present one beat, hold it until taken, then log its expected result.
  task automatic send_beat(in_t item);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(subset_result(item, universe_reg));
    beats_sent++;
  endtask

  // Drop valid and wait for every outstanding result to leave the core.
  task automatic wait_results;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register writes only land on an empty pipeline.
  task automatic write_universe(cnt_t value);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    universe_reg  = value;
    universe_writes++;
  endtask

  task automatic send_random(int count);
    repeat (count) send_beat(random_beat(universe_reg));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and corner cases: full and empty universes, the last
  // subset, the unused kind and out-of-range operands.
  task automatic test_directed;
    // Reset value of the universe: 32 elements.
    send_beat(make_beat(KIND_RANK,   32'h0000_0000, 32'h0000_0000));
    send_beat(make_beat(KIND_RANK,   32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(make_beat(KIND_UNRANK, 32'h0000_0000, 32'h0000_0000));
    send_beat(make_beat(KIND_UNRANK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(make_beat(KIND_UNRANK, 32'h0000_0000, 32'h0000_0001));
    send_beat(make_beat(KIND_NEXT,   32'h0000_0000, 32'hFFFF_FFFF));
    send_beat(make_beat(KIND_NEXT,   32'h8000_0000, 32'h0000_0000));
    send_beat(make_beat(KIND_NEXT,   32'h8000_0001, 32'h0000_0000));
    send_beat(make_beat(KIND_NEXT,   32'h0000_0005, 32'h0000_0000));
    send_beat(make_beat(KIND_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Small universe: operands beyond it are rejected.
    write_universe(cnt_t'(4));
    send_beat(make_beat(KIND_RANK,   32'h0000_0010, 32'h0000_0000));
    send_beat(make_beat(KIND_UNRANK, 32'h0000_0000, 32'h0000_0010));
    send_beat(make_beat(KIND_UNRANK, 32'h0000_0000, 32'h0000_000F));
    send_beat(make_beat(KIND_NEXT,   32'h0000_0008, 32'h0000_0000));
    send_beat(make_beat(KIND_NEXT,   32'h0000_000F, 32'h0000_0000));
    send_beat(make_beat(KIND_NEXT,   32'h0000_0020, 32'h0000_0000));
    // Empty universe: only the empty set exists.
    write_universe(cnt_t'(0));
    send_beat(make_beat(KIND_RANK,   32'h0000_0000, 32'h0000_0000));
    send_beat(make_beat(KIND_UNRANK, 32'h0000_0000, 32'h0000_0000));
    send_beat(make_beat(KIND_UNRANK, 32'h0000_0000, 32'h0000_0001));
    send_beat(make_beat(KIND_NEXT,   32'h0000_0000, 32'h0000_0000));
    send_beat(make_beat(KIND_NEXT,   32'h0000_0001, 32'h0000_0000));
    // Oversized register value saturates to 32.
    write_universe(cnt_t'(63));
    send_beat(make_beat(KIND_UNRANK, 32'h0000_0000, 32'hFFFF_FFFF));
    send_beat(make_beat(KIND_NEXT,   32'h8000_0000, 32'h0000_0000));
    send_beat(make_beat(KIND_RANK,   32'h7FFF_FFFF, 32'h0000_0000));
  endtask

  // Random beats across a spread of universe sizes, extremes included.
  task automatic test_universe_sweep;
    int sizes[11] = '{32, 0, 1, 2, 3, 5, 8, 16, 31, 33, 63};
    foreach (sizes[i]) begin
      write_universe(cnt_t'(sizes[i]));
      send_random(120);
    end
    repeat (2) begin
      write_universe(cnt_t'($urandom_range(0, 63)));
      send_random(60);
    end
  endtask

  // Back-to-back beats with the output never stalled.
  task automatic test_full_rate;
    write_universe(cnt_t'(32));
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    send_random(300);
    wait_results();
    send_idle_pct  = IDLE_PCT;
    sink_stall_pct = IDLE_PCT;
  endtask

  // Bursts separated by a full drain of the pipeline.
  task automatic test_burst_drain;
    write_universe(cnt_t'(20));
    repeat (3) begin
      send_random(40);
      wait_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the result monitor
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_stall <= (sink_stall_pct != 0) && ($urandom_range(0, 99) < sink_stall_pct);
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_data.rank_out), 64'd0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data.subset_mask_out !== want.subset_mask_out)
          report_mismatch("subset_mask_out", 64'(out_data.subset_mask_out),
                          64'(want.subset_mask_out));
        if (out_data.member_count !== want.member_count)
          report_mismatch("member_count", 64'(out_data.member_count),
                          64'(want.member_count));
        if (out_data.rank_out !== want.rank_out)
          report_mismatch("rank_out", 64'(out_data.rank_out), 64'(want.rank_out));
        if (out_data.has_next !== want.has_next)
          report_mismatch("has_next", 64'(out_data.has_next), 64'(want.has_next));
        if (out_data.bad_input !== want.bad_input)
          report_mismatch("bad_input", 64'(out_data.bad_input), 64'(want.bad_input));
      end
    end
  end

  // Watchdog: abandon a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_universe_sweep();
    test_full_rate();
    test_burst_drain();

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never returned", 64'(pending_results.size()), 64'd0);

    $display("ran %0d beats, %0d results compared, %0d universe writes",
             beats_sent, results_checked, universe_writes);
    $display("rank, unrank, successor and spare kind over universes 0..63, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/lsr_pkg.sv
rtl/lsr_front.sv
rtl/lsr_unrank_stage.sv
rtl/lsr_rank.sv
rtl/lex_subset_rank_unrank_core.sv
rtl/lsr_checker.sv
bench/tb.sv
